FILE: rtl/core/integer_to_ascii_formatter_assert.svh
// Assertion macros used by the formatter queue RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define ITAF_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("itaf: assertion failed");

// Next-cycle implication.
`define ITAF_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("itaf: assertion failed");

`endif

FILE: rtl/core/itaf_pkg.sv
package itaf_pkg;

  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_HEXL = 3'd2,
    ACT_HEXU = 3'd3,
    ACT_PTR  = 3'd4
  } itaf_action_e;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } itaf_prefix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_HEX,
    ST_LOAD,
    ST_EMIT
  } itaf_state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] value;
  } itaf_in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic [4:0] char_position;
    logic       last_char;
  } itaf_out_t;

  // One classified value waiting for conversion
  typedef struct packed {
    itaf_prefix_e prefix;
    logic         hex;
    logic         upper;
    logic [63:0]  mag;
  } itaf_job_t;

  // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned DIGIT_DEPTH = 16;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_N       = 8'h6E;
  localparam logic [7:0] CHAR_I       = 8'h69;
  localparam logic [7:0] CHAR_L       = 8'h6C;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;

  function automatic logic [4:0] prefix_len(itaf_prefix_e pfx);
    logic [4:0] len;
    case (pfx)
      PFX_MINUS: len = 5'd1;
      PFX_HEX:   len = 5'd2;
      PFX_NIL:   len = 5'd5;
      default:   len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] prefix_char(itaf_prefix_e pfx, logic [2:0] idx);
    logic [7:0] ch;
    case (pfx)
      PFX_MINUS: ch = CHAR_MINUS;
      PFX_HEX:   ch = (idx == 3'd0) ? CHAR_ZERO : CHAR_X;
      PFX_NIL: begin
        case (idx)
          3'd0:    ch = CHAR_LPAREN;
          3'd1:    ch = CHAR_N;
          3'd2:    ch = CHAR_I;
          3'd3:    ch = CHAR_L;
          default: ch = CHAR_RPAREN;
        endcase
      end
      default:   ch = CHAR_ZERO;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + {4'b0, d};
    end else begin
      ch = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'b0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

FILE: rtl/core/integer_to_ascii_formatter.sv
// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid_i / in_stall_o   | itaf_in_t (action, value)
// out     | output    | out_valid_o / out_stall_i | itaf_out_t (text_char, char_position,
//         |           |                           |   last_char)
//
// Steps: decimal passes the multiply and subtract states per digit in the
// divide-by-ten unit and hex one hex state per digit; then a load state primes
// the digit store read, and characters go out one per cycle while out_stall_i is low.
// A two-entry queue lets new words be taken while the converter is busy.
// Reset clears all control state; the digit store needs no clearing.
// out_stall_i holds the output register; in_stall_o rises only when the queue is full.
module integer_to_ascii_formatter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itaf_pkg::itaf_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itaf_pkg::itaf_out_t out_word_o
);
  import itaf_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  itaf_job_t push_job;
  itaf_job_t pop_job;

  // Classify incoming words
  itaf_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  // Buffer classified words
  itaf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  // Convert and emit characters
  itaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: rtl/core/itaf_front.sv
module itaf_front (
  input  logic               in_valid_i,
  input  itaf_pkg::itaf_in_t in_word_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output itaf_pkg::itaf_job_t q_job_o
);
  import itaf_pkg::*;

  logic        keep;
  logic [31:0] low_word;

  assign low_word = in_word_i.value[31:0];

  // Classify the word: prefix, radix, letter case and magnitude
  always_comb begin
    keep           = 1'b1;
    q_job_o.prefix = PFX_NONE;
    q_job_o.hex    = 1'b0;
    q_job_o.upper  = 1'b0;
    q_job_o.mag    = {32'b0, low_word};
    case (itaf_action_e'(in_word_i.action))
      ACT_SDEC: begin
        if (low_word[31]) begin
          q_job_o.prefix = PFX_MINUS;
          q_job_o.mag    = {32'b0, 32'd0 - low_word};
        end
      end
      ACT_UDEC: begin
        q_job_o.hex = 1'b0;
      end
      ACT_HEXL: begin
        q_job_o.hex = 1'b1;
      end
      ACT_HEXU: begin
        q_job_o.hex   = 1'b1;
        q_job_o.upper = 1'b1;
      end
      ACT_PTR: begin
        q_job_o.hex    = 1'b1;
        q_job_o.mag    = in_word_i.value;
        q_job_o.prefix = (in_word_i.value == 64'd0) ? PFX_NIL : PFX_HEX;
      end
      default: begin
        // drop unused mode codes
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

FILE: rtl/core/itaf_queue.sv
`include "integer_to_ascii_formatter_assert.svh"

module itaf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  itaf_pkg::itaf_job_t push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output itaf_pkg::itaf_job_t pop_job_o
);
  import itaf_pkg::*;

  itaf_job_t  ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop_job_o = ent_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entries until overwritten
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_job_i;
    end
  end

  `ITAF_ASSERT_IMP(a_no_push_full, push_i, count_q != 2'd2)
  `ITAF_ASSERT_IMP(a_no_pop_empty, pop_i, count_q != 2'd0)
  `ITAF_ASSERT_NXT(a_push_grows, push_i && !pop_i, count_q == $past(count_q) + 2'd1)

endmodule

FILE: rtl/core/itaf_back.sv
module itaf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  itaf_pkg::itaf_job_t job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itaf_pkg::itaf_out_t out_word_o
);
  import itaf_pkg::*;

  itaf_state_e  state_q, state_d;
  logic [63:0]  work_q, work_d;
  logic [31:0]  quot_q, quot_d;
  logic [4:0]   dcount_q, dcount_d;
  logic [4:0]   pos_q, pos_d;
  logic [3:0]   dptr_q, dptr_d;
  itaf_prefix_e prefix_q, prefix_d;
  logic         upper_q, upper_d;
  logic         out_valid_q, out_valid_d;
  itaf_out_t    out_q, out_d;

  logic [3:0]  digit_mem_q [DIGIT_DEPTH];
  logic [3:0]  rd_q;
  logic        mem_we;
  logic [3:0]  mem_wdata;

  logic [63:0] prod;
  logic [31:0] rem;
  logic        out_free;
  logic [4:0]  plen;
  logic [4:0]  total;
  logic        is_digit;
  logic        hex_done;
  logic        emit_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign plen      = prefix_len(prefix_q);
  assign total     = plen + dcount_q;
  assign is_digit  = (pos_q >= plen);
  assign emit_last = (pos_q == total - 5'd1);
  assign hex_done  = (work_q[63:4] == 60'd0) || (dcount_q == 5'd15);

  // Divide by ten through the reciprocal, remainder by shift and add
  assign prod = work_q[31:0] * RECIP10;
  assign rem  = work_q[31:0] - ((quot_q << 3) + (quot_q << 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.prefix == PFX_NIL) begin
            state_d = ST_EMIT;
          end else if (job_i.hex) begin
            state_d = ST_HEX;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:  state_d = ST_SUB;
      ST_SUB:  state_d = (quot_q == 32'd0) ? ST_LOAD : ST_MUL;
      ST_HEX:  state_d = hex_done ? ST_LOAD : ST_HEX;
      ST_LOAD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output controls
  always_comb begin
    job_pop_o   = 1'b0;
    work_d      = work_q;
    quot_d      = quot_q;
    dcount_d    = dcount_q;
    pos_d       = pos_q;
    dptr_d      = dptr_q;
    prefix_d    = prefix_q;
    upper_d     = upper_q;
    mem_we      = 1'b0;
    mem_wdata   = rem[3:0];
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          work_d    = job_i.mag;
          prefix_d  = job_i.prefix;
          upper_d   = job_i.upper;
          dcount_d  = 5'd0;
          pos_d     = 5'd0;
        end
      end
      ST_MUL: begin
        quot_d = {3'b0, prod[63:RECIP_SHIFT]};
      end
      ST_SUB: begin
        mem_we    = 1'b1;
        mem_wdata = rem[3:0];
        work_d    = {32'b0, quot_q};
        dcount_d  = dcount_q + 5'd1;
      end
      ST_HEX: begin
        mem_we    = 1'b1;
        mem_wdata = work_q[3:0];
        work_d    = {4'b0, work_q[63:4]};
        dcount_d  = dcount_q + 5'd1;
      end
      ST_LOAD: begin
        dptr_d = dcount_q[3:0] - 4'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.char_position = pos_q;
          out_d.last_char     = emit_last;
          if (is_digit) begin
            out_d.text_char = digit_char(rd_q, upper_q);
            dptr_d          = dptr_q - 4'd1;
          end else begin
            out_d.text_char = prefix_char(prefix_q, pos_q[2:0]);
          end
          pos_d = pos_q + 5'd1;
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      work_q      <= 64'd0;
      dcount_q    <= 5'd0;
      pos_q       <= 5'd0;
      dptr_q      <= 4'd0;
      prefix_q    <= PFX_NONE;
      upper_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      work_q      <= work_d;
      dcount_q    <= dcount_d;
      pos_q       <= pos_d;
      dptr_q      <= dptr_d;
      prefix_q    <= prefix_d;
      upper_q     <= upper_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    out_q  <= out_d;
  end

  // Digit store, least significant digit at the lowest address
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem_q[dcount_q[3:0]] <= mem_wdata;
    end
    rd_q <= digit_mem_q[dptr_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
